FILE: design/ideq_pkg.sv
// ideq_pkg: shared types and constants for the indexed deque with membership
// holds beat structs, op and error codes, controller states and default sizes
// no dependencies
package ideq_pkg;

  localparam int unsigned ENTRY_COUNT_DEF = 1024;
  localparam int unsigned INDEX_W         = 10;
  localparam int unsigned COUNT_W         = 11;
  localparam int unsigned OP_W            = 3;
  localparam int unsigned ERR_W           = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_QUERY      = 3'd5,
    OP_CLEAR      = 3'd6
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK      = 2'd0,
    ERR_PRESENT = 2'd1,
    ERR_EMPTY   = 2'd2,
    ERR_ABSENT  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    ST_SWEEP = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] front_index;
    logic [INDEX_W-1:0] back_index;
    logic [COUNT_W-1:0] item_count;
    logic               is_empty;
    logic               is_full;
    logic               is_member;
    logic [ERR_W-1:0]   error_code;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic sweep_last;
  } status_t;

endpackage

FILE: design/indexed_deque_with_membership.sv
// indexed_deque_with_membership: top level of the indexed deque with membership bits
// joins the controller and the datapath
// depends on ideq_pkg, ideq_ctrl, ideq_dpath, ideq_ram
//
// usage
//   request: drive req_i (op, index) and raise start; the beat is taken at a
//   rising edge where start is high and busy is low
//   result: done_o is high for exactly one cycle with rsp_o holding front, back,
//   count, empty, full, member flags and the error code; no back pressure
//   the result strobe is registered after the execute state that follows the
//   accepting edge; a new beat is taken only back in idle, after the registered
//   read of the link and membership memories and the link write back
//   clear: the result comes as usual, then busy stays high while the membership
//   memory is swept to zero
//   reset: rst_ni is asynchronous, active low; afterwards busy stays high while
//   the membership memory is cleared
//   link memory contents are never reset; only links of held indices are used
module indexed_deque_with_membership #(
  parameter int unsigned ENTRY_COUNT = ideq_pkg::ENTRY_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ideq_pkg::req_t req_i,
  output logic           done_o,
  output ideq_pkg::rsp_t rsp_o
);
  import ideq_pkg::*;

  cmd_t    cmd;
  status_t status;

  ideq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  ideq_dpath #(.ENTRY_COUNT(ENTRY_COUNT)) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (req_i),
    .status_o (status),
    .done_o   (done_o),
    .rsp_o    (rsp_o)
  );

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result strobe missing after accepted beat");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without work in progress");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.is_empty) |->
      (rsp_o.item_count == '0 && rsp_o.front_index == '0 && rsp_o.back_index == '0))
    else $error("empty deque reports nonzero fields");

  a_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.is_empty && rsp_o.is_full))
    else $error("deque reported empty and full together");

endmodule

FILE: design/ideq_ram.sv
// ideq_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module ideq_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ideq_ctrl.sv
// ideq_ctrl: controller state machine for the indexed deque
// sequences capture, execute and the membership clearing sweep
// depends on ideq_pkg
module ideq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  ideq_pkg::status_t status_i,
  output ideq_pkg::cmd_t    cmd_o,
  output logic              busy
);
  import ideq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = status_i.op_clear ? ST_SWEEP : ST_IDLE;
      end
      default: begin
        state_d = ST_SWEEP;
      end
    endcase
  end

endmodule

FILE: design/ideq_dpath.sv
// ideq_dpath: link and membership memories, pointers, count and result register
// depends on ideq_pkg and ideq_ram
module ideq_dpath #(
  parameter int unsigned ENTRY_COUNT = ideq_pkg::ENTRY_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ideq_pkg::cmd_t    cmd_i,
  input  ideq_pkg::req_t    req_i,
  output ideq_pkg::status_t status_o,
  output logic              done_o,
  output ideq_pkg::rsp_t    rsp_o
);
  import ideq_pkg::*;

  localparam int unsigned PTR_W = $clog2(ENTRY_COUNT);
  localparam int unsigned CNT_W = $clog2(ENTRY_COUNT + 1);

  logic [PTR_W-1:0]   front_q, front_d, back_q, back_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [OP_W-1:0]    op_q;
  logic [INDEX_W-1:0] idx_q;
  logic [PTR_W-1:0]   tgt_q, tgt_d;
  logic [PTR_W-1:0]   sweep_q;
  logic               done_q;
  rsp_t               rsp_q, rsp_d;

  logic [PTR_W-1:0] nxt_rd, prv_rd;
  logic [0:0]       pres_rd;
  logic             valid, held, unlink, sweep_last;
  logic [PTR_W-1:0] idx_ptr;
  err_e             err;
  logic             member;

  logic             nl_we, pl_we, pr_we, pres_we;
  logic [PTR_W-1:0] nl_addr, nl_data, pl_addr, pl_data, pr_addr, pres_addr;
  logic             pr_data, pres_data;

  // unlink target of the accepted beat
  always_comb begin
    case (op_e'(req_i.op))
      OP_POP_FRONT: tgt_d = front_q;
      OP_POP_BACK:  tgt_d = back_q;
      default:      tgt_d = PTR_W'(req_i.index);
    endcase
  end

  ideq_ram #(.WIDTH(PTR_W), .DEPTH(ENTRY_COUNT)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nl_we),
    .waddr_i (nl_addr),
    .wdata_i (nl_data),
    .re_i    (cmd_i.capture),
    .raddr_i (tgt_d),
    .rdata_o (nxt_rd)
  );

  ideq_ram #(.WIDTH(PTR_W), .DEPTH(ENTRY_COUNT)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (pl_addr),
    .wdata_i (pl_data),
    .re_i    (cmd_i.capture),
    .raddr_i (tgt_d),
    .rdata_o (prv_rd)
  );

  ideq_ram #(.WIDTH(1), .DEPTH(ENTRY_COUNT)) u_present_ram (
    .clk_i   (clk_i),
    .we_i    (pres_we),
    .waddr_i (pres_addr),
    .wdata_i (pres_data),
    .re_i    (cmd_i.capture),
    .raddr_i (PTR_W'(req_i.index)),
    .rdata_o (pres_rd)
  );

  assign valid   = 32'(idx_q) < ENTRY_COUNT;
  assign held    = valid & pres_rd[0];
  assign idx_ptr = PTR_W'(idx_q);

  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    count_d = count_q;
    err     = ERR_OK;
    member  = held;
    unlink  = 1'b0;
    nl_we   = 1'b0;
    nl_addr = idx_ptr;
    nl_data = front_q;
    pl_we   = 1'b0;
    pl_addr = idx_ptr;
    pl_data = back_q;
    pr_we   = 1'b0;
    pr_addr = idx_ptr;
    pr_data = 1'b0;
    case (op_e'(op_q))
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (!valid) begin
          err = ERR_ABSENT;
        end else if (held) begin
          err = ERR_PRESENT;
        end else begin
          pr_we   = 1'b1;
          pr_data = 1'b1;
          count_d = count_q + 1'b1;
          member  = 1'b1;
          if (count_q == '0) begin
            front_d = idx_ptr;
            back_d  = idx_ptr;
          end else if (op_e'(op_q) == OP_PUSH_FRONT) begin
            nl_we   = 1'b1;
            nl_addr = idx_ptr;
            nl_data = front_q;
            pl_we   = 1'b1;
            pl_addr = front_q;
            pl_data = idx_ptr;
            front_d = idx_ptr;
          end else begin
            pl_we   = 1'b1;
            pl_addr = idx_ptr;
            pl_data = back_q;
            nl_we   = 1'b1;
            nl_addr = back_q;
            nl_data = idx_ptr;
            back_d  = idx_ptr;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (count_q == '0) begin
          err = ERR_EMPTY;
        end else begin
          unlink = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!held) begin
          err = ERR_ABSENT;
        end else begin
          unlink = 1'b1;
        end
      end
      OP_CLEAR: begin
        front_d = '0;
        back_d  = '0;
        count_d = '0;
        member  = 1'b0;
      end
      default: begin
      end
    endcase

    if (unlink) begin
      pr_we   = 1'b1;
      pr_addr = tgt_q;
      pr_data = 1'b0;
      count_d = count_q - 1'b1;
      member  = held && (tgt_q != idx_ptr);
      if (count_d == '0) begin
        front_d = '0;
        back_d  = '0;
      end else if (tgt_q == front_q) begin
        front_d = nxt_rd;
      end else if (tgt_q == back_q) begin
        back_d = prv_rd;
      end else begin
        nl_we   = 1'b1;
        nl_addr = prv_rd;
        nl_data = nxt_rd;
        pl_we   = 1'b1;
        pl_addr = nxt_rd;
        pl_data = prv_rd;
      end
    end

    nl_we = nl_we & cmd_i.execute;
    pl_we = pl_we & cmd_i.execute;
  end

  // membership writes, the clearing sweep takes the port while it runs
  assign pres_we   = cmd_i.sweep | (cmd_i.execute & pr_we);
  assign pres_addr = cmd_i.sweep ? sweep_q : pr_addr;
  assign pres_data = cmd_i.sweep ? 1'b0 : pr_data;

  assign sweep_last = sweep_q == PTR_W'(ENTRY_COUNT - 1);

  always_comb begin
    rsp_d.front_index = (count_d != '0) ? INDEX_W'(front_d) : '0;
    rsp_d.back_index  = (count_d != '0) ? INDEX_W'(back_d) : '0;
    rsp_d.item_count  = COUNT_W'(count_d);
    rsp_d.is_empty    = count_d == '0;
    rsp_d.is_full     = count_d == CNT_W'(ENTRY_COUNT);
    rsp_d.is_member   = member;
    rsp_d.error_code  = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
      sweep_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.execute;
      if (cmd_i.execute) begin
        front_q <= front_d;
        back_q  <= back_d;
        count_q <= count_d;
      end
      if (cmd_i.sweep) begin
        sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= req_i.op;
      idx_q <= req_i.index;
      tgt_q <= tgt_d;
    end
    if (cmd_i.execute) begin
      rsp_q <= rsp_d;
    end
  end

  assign status_o.op_clear   = op_e'(op_q) == OP_CLEAR;
  assign status_o.sweep_last = sweep_last;
  assign done_o              = done_q;
  assign rsp_o               = rsp_q;

endmodule
